>>> design/pta_pkg.sv
`default_nettype none

package pta_pkg;

  // Coordinate differences and their magnitudes
  localparam int DW = 15;
  localparam int MW = 15;

  // Square root of (dx^2 + dz^2) * 2^32, one result bit per stage
  localparam int SW = 30;
  localparam int QW = 31;
  localparam int RW = 33;
  localparam int SQRT_STAGES = QW;
  localparam int SQRT_S_STAGES = SW / 2 - 1;

  // Vectoring rotator
  localparam int IN_SHIFT = 16;
  localparam int XW = 34;
  localparam int ZW = 38;
  localparam int ACC_FRAC = 30;
  localparam int CORDIC_ITERS = 32;

  localparam logic signed [ZW-1:0] NINETY_ACC = 38'sd96636764160;
  localparam logic [63:0] DEG_PER_RAD_Q = 64'd61520874802;
  localparam logic [63:0] ATAN_HEAD [8] = '{
    64'd48318382080, 64'd28524006506, 64'd15071301663, 64'd7650428051,
    64'd3840059795, 64'd1921901881, 64'd961185452, 64'd480622056
  };

  typedef enum logic [1:0] {
    CFG_TURRET_X = 2'd0,
    CFG_TURRET_Y = 2'd1,
    CFG_TURRET_Z = 2'd2,
    CFG_MIRROR   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic          laser;
    logic          present;
    logic          dx_zero;
    logic          dx_neg;
    logic          h_zero;
    logic          dy_zero;
    logic          dy_neg;
    logic [MW-1:0] adx;
    logic [MW-1:0] ady;
    logic [MW-1:0] adz;
  } sb_t;

  // Shift right, rounding toward zero
  function automatic logic signed [XW-1:0] shz(input logic signed [XW-1:0] v, input int s);
    logic signed [XW-1:0] m;
    m = -v;
    if (v[XW-1]) return -(m >>> s);
    return v >>> s;
  endfunction

  // atan(2^-i) in degrees with ACC_FRAC fraction bits
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic [63:0] e;
    if (i < 8) e = ATAN_HEAD[i[2:0]];
    else e = (DEG_PER_RAD_Q >> i) - ((DEG_PER_RAD_Q >> (3 * i)) / 64'd3);
    return e[ZW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/pan_tilt_aiming_angles.sv
// Pan/tilt aiming angles for a turret.
// Input channel (in_valid / in_stall): one target position in millimetres and
// a laser request per item. Result channel (out_valid / out_stall): pan and
// tilt in whole degrees (0..179), the laser request passed through, and a
// target-present flag that drops for an all-zero target (angles 90, 90).
// Configuration: write turret x/y/z and the tilt mirror bit through
// cfg_wr_en / cfg_index / cfg_wdata while no item is in flight.
// Pipeline: the coordinate differences, the squares, the bit-per-stage square
// root, the unrolled vectoring rotators (pan and tilt side by side) and the
// output register. Throughput: one item per cycle while the receiver does
// not stall a waiting result.
// Reset (rst_n low, synchronous) empties the pipeline and clears the turret
// position and mirror bit to zero.
// When the receiver stalls a waiting result the whole pipeline holds and
// in_stall rises in the same cycle; bubbles move on whenever it does not.
`default_nettype none

module pan_tilt_aiming_angles #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] in_target_x_mm,
  input  wire logic [13:0] in_target_y_mm,
  input  wire logic [13:0] in_target_z_mm,
  input  wire logic        in_laser_request,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_pan_deg,
  output logic [7:0]       out_tilt_deg,
  output logic             out_laser_on,
  output logic             out_target_present,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_wdata
);

  localparam int DW = pta_pkg::DW;
  localparam int MW = pta_pkg::MW;
  localparam int SW = pta_pkg::SW;
  localparam int QW = pta_pkg::QW;
  localparam int XW = pta_pkg::XW;
  localparam int ZW = pta_pkg::ZW;
  localparam int ACC_FRAC = pta_pkg::ACC_FRAC;
  localparam int SB_DEPTH = pta_pkg::SQRT_STAGES + pta_pkg::CORDIC_ITERS;
  localparam int CIN = pta_pkg::SQRT_STAGES - 1;
  // Angle with F fraction bits, signed, room for +/-180 degrees
  localparam int F  = ANGLE_FRAC_BITS;
  localparam int AW = F + 9;
  localparam logic signed [AW-1:0] NINETY_Q = AW'(90) << F;
  localparam logic signed [AW-1:0] ONE80_Q  = AW'(180) << F;

  // Configuration registers
  logic [13:0] cfg_x_r, cfg_y_r, cfg_z_r;
  logic        cfg_mirror_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_x_r      <= '0;
      cfg_y_r      <= '0;
      cfg_z_r      <= '0;
      cfg_mirror_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pta_pkg::CFG_TURRET_X: cfg_x_r      <= cfg_wdata;
        pta_pkg::CFG_TURRET_Y: cfg_y_r      <= cfg_wdata;
        pta_pkg::CFG_TURRET_Z: cfg_z_r      <= cfg_wdata;
        pta_pkg::CFG_MIRROR:   cfg_mirror_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Global advance: freeze everything while a result waits on a stalled sink
  logic adv;
  assign adv      = ~out_valid | ~out_stall;
  assign in_stall = ~adv;

  // Stage A: differences and magnitudes
  logic signed [DW-1:0] dx, dy, dz;
  logic                 vld_a_r;
  pta_pkg::sb_t         sb_a_nxt, sb_a_r;

  always_comb begin
    dx = $signed({cfg_x_r[13], cfg_x_r}) - $signed({in_target_x_mm[13], in_target_x_mm});
    dy = $signed({cfg_y_r[13], cfg_y_r}) - $signed({in_target_y_mm[13], in_target_y_mm});
    dz = $signed({cfg_z_r[13], cfg_z_r}) - $signed({in_target_z_mm[13], in_target_z_mm});
    sb_a_nxt.laser   = in_laser_request;
    sb_a_nxt.present = |{in_target_x_mm, in_target_y_mm, in_target_z_mm};
    sb_a_nxt.dx_zero = (dx == '0);
    sb_a_nxt.dx_neg  = dx[DW-1];
    sb_a_nxt.h_zero  = (dx == '0) && (dz == '0);
    sb_a_nxt.dy_zero = (dy == '0);
    sb_a_nxt.dy_neg  = dy[DW-1];
    sb_a_nxt.adx     = dx[DW-1] ? MW'(-dx) : MW'(dx);
    sb_a_nxt.ady     = dy[DW-1] ? MW'(-dy) : MW'(dy);
    sb_a_nxt.adz     = dz[DW-1] ? MW'(-dz) : MW'(dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_a_r <= 1'b0;
    else if (adv) vld_a_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) sb_a_r <= sb_a_nxt;
  end

  // Stage B: squared planar distance
  logic [2*MW-1:0] sq_x, sq_z;
  logic [SW:0]     sq_sum;
  logic [SW-1:0]   s_b_r;
  logic            vld_b_r;
  pta_pkg::sb_t    sb_b_r;

  always_comb begin
    sq_x   = sb_a_r.adx * sb_a_r.adx;
    sq_z   = sb_a_r.adz * sb_a_r.adz;
    sq_sum = {1'b0, sq_x[SW-1:0]} + {1'b0, sq_z[SW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_b_r <= 1'b0;
    else if (adv) vld_b_r <= vld_a_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_b_r <= sb_a_r;
      s_b_r  <= sq_sum[SW-1:0];
    end
  end

  // Side line: flags and magnitudes travel alongside the root and rotators
  logic         vld_r [SB_DEPTH];
  pta_pkg::sb_t sb_r  [SB_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SB_DEPTH; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= vld_b_r;
      for (int k = 1; k < SB_DEPTH; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb_b_r;
      for (int k = 1; k < SB_DEPTH; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // Hypotenuse with 16 fraction bits
  logic [QW-1:0] hyp;

  pta_isqrt u_isqrt (
    .clk   (clk),
    .en    (adv),
    .s_in  (s_b_r),
    .h_out (hyp)
  );

  // Rotators: pan from (|dx|, |dz|), elevation from (hyp, |dy|)
  logic signed [XW-1:0] pan_x0, pan_y0, tilt_x0, tilt_y0;
  logic signed [ZW-1:0] pan_z, tilt_z;

  assign pan_x0  = {3'b000, sb_r[CIN].adx, 16'h0000};
  assign pan_y0  = {3'b000, sb_r[CIN].adz, 16'h0000};
  assign tilt_x0 = {3'b000, hyp};
  assign tilt_y0 = {3'b000, sb_r[CIN].ady, 16'h0000};

  pta_cordic u_cordic_pan (
    .clk   (clk),
    .en    (adv),
    .x_in  (pan_x0),
    .y_in  (pan_y0),
    .z_out (pan_z)
  );

  pta_cordic u_cordic_tilt (
    .clk   (clk),
    .en    (adv),
    .x_in  (tilt_x0),
    .y_in  (tilt_y0),
    .z_out (tilt_z)
  );

  // Output stage: clamp to 0..90, truncate to F fraction bits, fold to degrees
  pta_pkg::sb_t         sb_o;
  logic signed [ZW-1:0] pan_zc, tilt_zc;
  logic [F+6:0]         pan_a, tilt_a;
  logic signed [AW-1:0] pan_v, tilt_e, tilt_v;
  logic [7:0]           pan_w, tilt_w, pan_nxt, tilt_nxt;

  always_comb begin
    sb_o = sb_r[SB_DEPTH-1];

    if (pan_z[ZW-1]) pan_zc = '0;
    else if (pan_z > pta_pkg::NINETY_ACC) pan_zc = pta_pkg::NINETY_ACC;
    else pan_zc = pan_z;

    if (tilt_z[ZW-1]) tilt_zc = '0;
    else if (tilt_z > pta_pkg::NINETY_ACC) tilt_zc = pta_pkg::NINETY_ACC;
    else tilt_zc = tilt_z;

    pan_a  = pan_zc[ACC_FRAC+6 : ACC_FRAC-F];
    tilt_a = tilt_zc[ACC_FRAC+6 : ACC_FRAC-F];

    // Target behind the turret: fold into the far half
    pan_v = sb_o.dx_neg ? ONE80_Q - $signed({2'b00, pan_a}) : $signed({2'b00, pan_a});
    pan_w = pan_v[F+7:F];

    if (sb_o.h_zero) begin
      if (sb_o.dy_zero) tilt_e = '0;
      else tilt_e = sb_o.dy_neg ? -NINETY_Q : NINETY_Q;
    end else begin
      tilt_e = sb_o.dy_neg ? -$signed({2'b00, tilt_a}) : $signed({2'b00, tilt_a});
    end
    tilt_v = cfg_mirror_r ? NINETY_Q + tilt_e : NINETY_Q - tilt_e;
    tilt_w = tilt_v[F+7:F];

    if (!sb_o.present || sb_o.dx_zero) pan_nxt = 8'd90;
    else pan_nxt = (pan_w == 8'd180) ? 8'd0 : pan_w;

    if (!sb_o.present) tilt_nxt = 8'd90;
    else tilt_nxt = (tilt_w == 8'd180) ? 8'd0 : tilt_w;
  end

  logic       out_valid_r;
  logic [7:0] pan_r, tilt_r;
  logic       laser_r, present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vld_r[SB_DEPTH-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_r     <= pan_nxt;
      tilt_r    <= tilt_nxt;
      laser_r   <= sb_o.laser;
      present_r <= sb_o.present;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pan_deg        = pan_r;
  assign out_tilt_deg       = tilt_r;
  assign out_laser_on       = laser_r;
  assign out_target_present = present_r;

endmodule

`default_nettype wire

>>> design/pta_isqrt.sv
`default_nettype none

module pta_isqrt (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [pta_pkg::SW-1:0]  s_in,
  output logic      [pta_pkg::QW-1:0]  h_out
);

  localparam int SW = pta_pkg::SW;
  localparam int QW = pta_pkg::QW;
  localparam int RW = pta_pkg::RW;
  localparam int NS = pta_pkg::SQRT_STAGES;
  localparam int NSS = pta_pkg::SQRT_S_STAGES;

  logic [QW-1:0] q_r [NS];
  logic [RW-1:0] r_r [NS];
  logic [SW-1:0] s_r [NSS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [QW-1:0] q_prev;
    logic [RW-1:0] r_prev;
    logic [1:0]    pair;
    logic [RW+1:0] r_sh;
    logic [RW+1:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign q_prev = '0;
      assign r_prev = '0;
    end else begin : g_next
      assign q_prev = q_r[j-1];
      assign r_prev = r_r[j-1];
    end

    // Low half of the radicand is zero: only early stages take digits
    if (j <= NSS) begin : g_digit
      logic [SW-1:0] s_prev;
      if (j == 0) begin : g_s0
        assign s_prev = s_in;
      end else begin : g_sn
        assign s_prev = s_r[j-1];
      end
      assign pair = s_prev[2*(NSS-j)+1 -: 2];
      if (j < NSS) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) s_r[j] <= s_prev;
        end
      end
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      r_sh  = {r_prev, pair};
      trial = {2'b00, q_prev, 2'b01};
      diff  = {1'b0, r_sh} - {1'b0, trial};
      ge    = ~diff[RW+2];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= {q_prev[QW-2:0], ge};
        r_r[j] <= ge ? diff[RW-1:0] : r_sh[RW-1:0];
      end
    end
  end

  assign h_out = q_r[NS-1];

endmodule

`default_nettype wire

>>> design/pta_cordic.sv
`default_nettype none

module pta_cordic (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [pta_pkg::XW-1:0]  x_in,
  input  wire logic signed [pta_pkg::XW-1:0]  y_in,
  output logic      signed [pta_pkg::ZW-1:0]  z_out
);

  localparam int XW = pta_pkg::XW;
  localparam int ZW = pta_pkg::ZW;
  localparam int N  = pta_pkg::CORDIC_ITERS;

  logic signed [XW-1:0] x_r [N-1];
  logic signed [XW-1:0] y_r [N-1];
  logic signed [ZW-1:0] z_r [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [XW-1:0] x_prev, y_prev, x_nxt, y_nxt, xs, ys;
    logic signed [ZW-1:0] z_prev, z_nxt;

    if (i == 0) begin : g_first
      assign x_prev = x_in;
      assign y_prev = y_in;
      assign z_prev = '0;
    end else begin : g_next
      assign x_prev = x_r[i-1];
      assign y_prev = y_r[i-1];
      assign z_prev = z_r[i-1];
    end

    // Residual already zero: hold the angle exact
    always_comb begin
      xs = pta_pkg::shz(x_prev, i);
      ys = pta_pkg::shz(y_prev, i);
      if (y_prev == '0) begin
        x_nxt = x_prev;
        y_nxt = y_prev;
        z_nxt = z_prev;
      end else if (!y_prev[XW-1]) begin
        x_nxt = x_prev + ys;
        y_nxt = y_prev - xs;
        z_nxt = z_prev + pta_pkg::atan_step(i);
      end else begin
        x_nxt = x_prev - ys;
        y_nxt = y_prev + xs;
        z_nxt = z_prev - pta_pkg::atan_step(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) z_r[i] <= z_nxt;
    end

    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i] <= x_nxt;
          y_r[i] <= y_nxt;
        end
      end
    end
  end

  assign z_out = z_r[N-1];

endmodule

`default_nettype wire

>>> design/pta_checker.sv
`default_nettype none

module pta_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_pan_deg,
  input wire logic [7:0]  out_tilt_deg,
  input wire logic        out_laser_on,
  input wire logic        out_target_present
);

  // Stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pan_deg)
      && $stable(out_tilt_deg) && $stable(out_laser_on) && $stable(out_target_present))
    else $error("result changed while stalled");

  // A stalled result freezes the whole pipeline
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pan_deg < 8'd180 && out_tilt_deg < 8'd180)
    else $error("angle out of range");

  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_target_present |-> out_pan_deg == 8'd90 && out_tilt_deg == 8'd90)
    else $error("absent target not at rest angles");

endmodule

bind pan_tilt_aiming_angles pta_checker u_pta_checker (.*);

`default_nettype wire
